// File: hdl/mdl_pkg.sv
// Package: shared constants, codes and types for the modular dense layer core.
`timescale 1ns / 1ps
`default_nettype none
package mdl_pkg;

  localparam int DATA_W       = 31;
  localparam int SUM_W        = 62;
  localparam int DIV_STEPS    = 31;
  localparam int IDX_W        = 6;
  localparam int CNT_REG_W    = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int DEF_MAX_IN   = 64;
  localparam int DEF_MAX_OUT  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 3'd0,
    REG_CUTOFF   = 3'd1,
    REG_THR_EN   = 3'd2,
    REG_INPUTS   = 3'd3,
    REG_OUTPUTS  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_WEIGHT  = 1'b0,
    CMD_ELEMENT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_ACC_DIV,
    ST_ACC_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_t;

endpackage
`default_nettype wire

// File: hdl/modular_dense_layer_threshold_argmax_core.sv
// Flow: an element request is processed for each used output in turn (read, multiply, add,
// 31 two-bit modulo steps, write back; the modulo steps are skipped with modulus zero).
// A weight request is written straight to the weight memory. The final element then emits the
// results one by one (accumulator memory read, then output register load), held by output stall.
// Reset: synchronous active-low rst_n clears control, config to defaults, accumulator
// valid bits and the element count; the weight memory is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module modular_dense_layer_threshold_argmax_core #(
  parameter int MAX_INPUTS  = mdl_pkg::DEF_MAX_IN,
  parameter int MAX_OUTPUTS = mdl_pkg::DEF_MAX_OUT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_command,
  input  wire logic [mdl_pkg::IDX_W-1:0]     in_weight_row,
  input  wire logic [mdl_pkg::IDX_W-1:0]     in_weight_col,
  input  wire logic [mdl_pkg::DATA_W-1:0]    in_data_value,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [mdl_pkg::IDX_W-1:0]     out_index,
  output      logic [mdl_pkg::DATA_W-1:0]    out_value,
  output      logic [mdl_pkg::IDX_W-1:0]     out_best_index,
  output      logic                          out_last,
  input  wire logic                          cfg_we,
  input  wire logic [mdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mdl_pkg::DATA_W-1:0]    cfg_wdata
);
  import mdl_pkg::*;

  localparam int IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CW    = $clog2(MAX_INPUTS + 1);
  localparam int DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DIV_STEPS);

  // configuration registers
  logic [DATA_W-1:0]    modulus_r, cutoff_r;
  logic                 thr_en_r;
  logic [CNT_REG_W-1:0] inputs_r, outputs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= '1;
      cutoff_r  <= '0;
      thr_en_r  <= 1'b1;
      inputs_r  <= CNT_REG_W'(64);
      outputs_r <= CNT_REG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS: modulus_r <= cfg_wdata;
        REG_CUTOFF:  cutoff_r  <= cfg_wdata;
        REG_THR_EN:  thr_en_r  <= cfg_wdata[0];
        REG_INPUTS:  inputs_r  <= cfg_wdata[CNT_REG_W-1:0];
        REG_OUTPUTS: outputs_r <= cfg_wdata[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [31:0]   d32, l32;
  logic [CW-1:0] d_eff;
  logic [OW-1:0] l_m1;
  always_comb begin
    d32 = 32'(inputs_r);
    l32 = 32'(outputs_r);
    if (d32 == 32'd0) d32 = 32'd1;
    else if (d32 > 32'(MAX_INPUTS)) d32 = 32'(MAX_INPUTS);
    if (l32 == 32'd0) l32 = 32'd1;
    else if (l32 > 32'(MAX_OUTPUTS)) l32 = 32'(MAX_OUTPUTS);
    d_eff = CW'(d32);
    l_m1  = OW'(l32 - 32'd1);
  end

  // control state
  state_t        state_r, state_nxt;
  logic [OW-1:0] j_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] step_r;
  logic          in_acc, out_free, j_last, div_done, vec_done;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign j_last   = (j_r == l_m1);
  assign div_done = (step_r == SW'(DIV_STEPS - 1));
  assign vec_done = ((cnt_r + CW'(1)) >= d_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:      if (in_acc && in_command == CMD_ELEMENT) state_nxt = ST_ACC_RD;
      ST_ACC_RD:    state_nxt = ST_ACC_MUL;
      ST_ACC_MUL:   state_nxt = ST_ACC_ADD;
      ST_ACC_ADD:   state_nxt = (modulus_r == '0) ? ST_ACC_WR : ST_ACC_DIV;
      ST_ACC_DIV:   if (div_done) state_nxt = ST_ACC_WR;
      ST_ACC_WR: begin
        if (!j_last)       state_nxt = ST_ACC_RD;
        else if (vec_done) state_nxt = ST_EMIT_RD;
        else               state_nxt = ST_IDLE;
      end
      ST_EMIT_RD:   state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: if (out_free) state_nxt = j_last ? ST_IDLE : ST_EMIT_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // weight memory
  logic [DATA_W-1:0] wmem [DEPTH];
  logic [DATA_W-1:0] w_rd_r;
  logic              w_in_range;
  logic [AW-1:0]     w_wr_addr, w_rd_addr;

  assign w_in_range = (32'(in_weight_row) < 32'(MAX_OUTPUTS)) &&
                      (32'(in_weight_col) < 32'(MAX_INPUTS));
  assign w_wr_addr  = AW'(32'(in_weight_row) * MAX_INPUTS + 32'(in_weight_col));
  assign w_rd_addr  = AW'(32'(j_r) * MAX_INPUTS + 32'(cnt_r[IW-1:0]));

  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_WEIGHT && w_in_range) wmem[w_wr_addr] <= in_data_value;
    if (state_r == ST_ACC_RD) w_rd_r <= wmem[w_rd_addr];
  end

  // accumulator memory, with valid bits standing for the all-zero reset
  logic [DATA_W-1:0]      amem [MAX_OUTPUTS];
  logic [DATA_W-1:0]      a_rd_r, a_val, a_wdata;
  logic [MAX_OUTPUTS-1:0] a_vld_r;
  logic                   a_vld_q_r;
  logic                   a_rd_en;

  assign a_rd_en = (state_r == ST_ACC_RD) || (state_r == ST_EMIT_RD);
  assign a_val   = a_vld_q_r ? a_rd_r : '0;

  always_ff @(posedge clk) begin
    if (state_r == ST_ACC_WR) amem[j_r] <= a_wdata;
    if (a_rd_en) a_rd_r <= amem[j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= '0;
      a_vld_q_r <= 1'b0;
    end else begin
      if (a_rd_en) a_vld_q_r <= a_vld_r[j_r];
      if (state_r == ST_ACC_WR) a_vld_r[j_r] <= 1'b1;
      else if (state_r == ST_EMIT_WAIT && out_free && j_last) a_vld_r <= '0;
    end
  end

  // multiply-accumulate and two-bit-per-cycle remainder
  logic [DATA_W-1:0] x_r, a_hold_r, rem_r, rem_nxt;
  logic [SUM_W-1:0]  prod_r, sum_r;
  logic [DATA_W:0]   t1, s1, t2, s2, m_ext;

  always_comb begin
    m_ext   = {1'b0, modulus_r};
    t1      = {rem_r, sum_r[SUM_W-1]};
    s1      = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    t2      = {s1[DATA_W-1:0], sum_r[SUM_W-2]};
    s2      = (t2 >= m_ext) ? (t2 - m_ext) : t2;
    rem_nxt = s2[DATA_W-1:0];
    a_wdata = (modulus_r == '0) ? sum_r[DATA_W-1:0] : rem_r;
  end

  always_ff @(posedge clk) begin
    if (in_acc) x_r <= in_data_value;
    case (state_r)
      ST_ACC_MUL: begin
        prod_r   <= SUM_W'(x_r) * SUM_W'(w_rd_r);
        a_hold_r <= a_val;
      end
      ST_ACC_ADD: begin
        sum_r <= prod_r + SUM_W'(a_hold_r);
        rem_r <= '0;
      end
      ST_ACC_DIV: begin
        sum_r <= {sum_r[SUM_W-3:0], 2'b00};
        rem_r <= rem_nxt;
      end
      default: ;
    endcase
  end

  // output index, element count and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r    <= '0;
      cnt_r  <= '0;
      step_r <= '0;
    end else begin
      if (state_r == ST_ACC_ADD) step_r <= '0;
      else if (state_r == ST_ACC_DIV) step_r <= step_r + SW'(1);
      if (state_r == ST_ACC_WR) begin
        if (!j_last) j_r <= j_r + OW'(1);
        else begin
          j_r   <= '0;
          cnt_r <= vec_done ? CW'(0) : (cnt_r + CW'(1));
        end
      end else if (state_r == ST_EMIT_WAIT && out_free) begin
        j_r <= j_last ? OW'(0) : (j_r + OW'(1));
      end
    end
  end

  // activation, argmax and output register
  logic [DATA_W-1:0] act_v, best_val_r;
  logic [OW-1:0]     best_idx_r, best_idx_new;
  logic              take;

  assign act_v        = (thr_en_r && (a_val < cutoff_r)) ? '0 : a_val;
  assign take         = (j_r == '0) || (act_v > best_val_r);
  assign best_idx_new = take ? j_r : best_idx_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT_WAIT && out_free && take) begin
      best_val_r <= act_v;
      best_idx_r <= j_r;
    end
    if (state_r == ST_EMIT_WAIT && out_free) begin
      out_index      <= IDX_W'(j_r);
      out_value      <= act_v;
      out_last       <= j_last;
      out_best_index <= j_last ? IDX_W'(best_idx_new) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (state_r == ST_EMIT_WAIT && out_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

`ifndef NO_ASSERTIONS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC_WR && modulus_r != '0) |-> (rem_r < modulus_r))
    else $error("remainder not below modulus");
  a_div_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC_DIV) |-> (modulus_r != '0))
    else $error("remainder unit running with zero modulus");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < CW'(MAX_INPUTS)))
    else $error("element count out of range");
  a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_best_index == '0))
    else $error("best index set on a non-final result");
`endif

endmodule
`default_nettype wire
